/* hw/rtl/llrpd_pkg.sv */
`timescale 1ns / 1ps

package llrpd_pkg;

   localparam int unsigned HDR_LEN     = 10;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned VER_W       = 3;
   localparam int unsigned TYPE_W      = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VERSION      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VERSION      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_LENGTH = 2'd2;

   localparam logic [VER_W-1:0]      MIN_VERSION_RST      = 3'd1;
   localparam logic [VER_W-1:0]      MAX_VERSION_RST      = 3'd1;
   localparam logic [CSR_DATA_W-1:0] MAX_FRAME_LENGTH_RST = 24'd4096;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_BODY    = 2'd1,
      KIND_DISCARD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_BAD_VERSION = 2'd1,
      STAT_SHORT       = 2'd2,
      STAT_LONG        = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0]       message_ident;
      logic [31:0]       message_length;
      logic [VER_W-1:0]  protocol_version;
      logic [TYPE_W-1:0] message_type;
      status_type        frame_status;
      logic              header_done;
      logic              frame_last;
      kind_type          byte_kind;
      logic [7:0]        out_byte;
   } result_type;

endpackage

/* hw/rtl/llrpd_parse.sv */
`timescale 1ns / 1ps

module llrpd_parse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [llrpd_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [llrpd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                take,
   input  logic [7:0]                          in_byte,
   input  logic                                chunk_end,
   output llrpd_pkg::result_type               result
);
   import llrpd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_BODY    = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   logic [VER_W-1:0]      min_version_ff;
   logic [VER_W-1:0]      max_version_ff;
   logic [CSR_DATA_W-1:0] max_frame_length_ff;

   phase_type   phase_ff,        phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [15:0] type_word_ff,    type_word_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] ident_shift_ff,  ident_shift_in;
   logic [31:0] bytes_left_ff,   bytes_left_in;

   logic [VER_W-1:0] version;
   logic             version_bad;
   logic [31:0]      ident_full;
   logic [31:0]      max_len;

   assign version     = in_byte[4:2];
   assign version_bad = (version < min_version_ff) || (version > max_version_ff);
   assign ident_full  = {ident_shift_ff[23:0], in_byte};
   assign max_len     = {{(32-CSR_DATA_W){1'b0}}, max_frame_length_ff};

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      type_word_in    = type_word_ff;
      length_shift_in = length_shift_ff;
      ident_shift_in  = ident_shift_ff;
      bytes_left_in   = bytes_left_ff;

      result                  = '0;
      result.out_byte         = in_byte;
      result.byte_kind        = KIND_HEADER;
      result.frame_status     = STAT_OK;

      case (phase_ff)
         PH_BODY: begin
            result.byte_kind = KIND_BODY;
            bytes_left_in    = (bytes_left_ff != 32'd0) ? bytes_left_ff - 32'd1 : 32'd0;
            if (bytes_left_in == 32'd0) begin
               result.frame_last = 1'b1;
               phase_in          = PH_HEADER;
               header_count_in   = 4'd0;
            end
         end
         PH_DISCARD: begin
            result.byte_kind = KIND_DISCARD;
            if (chunk_end) begin
               phase_in        = PH_HEADER;
               header_count_in = 4'd0;
            end
         end
         default: begin
            if (header_count_ff == 4'd0) begin
               type_word_in = {in_byte, 8'h00};
               if (version_bad) begin
                  result.byte_kind    = KIND_DISCARD;
                  result.frame_status = STAT_BAD_VERSION;
                  header_count_in     = 4'd0;
                  phase_in            = chunk_end ? PH_HEADER : PH_DISCARD;
               end else begin
                  header_count_in = 4'd1;
               end
            end else if (header_count_ff == 4'd1) begin
               type_word_in    = {type_word_ff[15:8], in_byte};
               header_count_in = 4'd2;
            end else if (header_count_ff < 4'd6) begin
               length_shift_in = {length_shift_ff[23:0], in_byte};
               header_count_in = header_count_ff + 4'd1;
            end else if (header_count_ff < 4'(HDR_LEN - 1)) begin
               ident_shift_in  = ident_full;
               header_count_in = header_count_ff + 4'd1;
            end else begin
               // tenth byte: header complete, check length
               ident_shift_in          = ident_full;
               result.header_done      = 1'b1;
               result.message_type     = type_word_ff[TYPE_W-1:0];
               result.protocol_version = type_word_ff[TYPE_W+VER_W-1:TYPE_W];
               result.message_length   = length_shift_ff;
               result.message_ident    = ident_full;
               header_count_in         = 4'd0;
               if (length_shift_ff < 32'(HDR_LEN)) begin
                  result.byte_kind    = KIND_DISCARD;
                  result.frame_status = STAT_SHORT;
                  phase_in            = chunk_end ? PH_HEADER : PH_DISCARD;
               end else if (length_shift_ff > max_len) begin
                  result.byte_kind    = KIND_DISCARD;
                  result.frame_status = STAT_LONG;
                  phase_in            = chunk_end ? PH_HEADER : PH_DISCARD;
               end else if (length_shift_ff == 32'(HDR_LEN)) begin
                  result.frame_last = 1'b1;
                  phase_in          = PH_HEADER;
               end else begin
                  bytes_left_in = length_shift_ff - 32'(HDR_LEN);
                  phase_in      = PH_BODY;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_version_ff      <= MIN_VERSION_RST;
         max_version_ff      <= MAX_VERSION_RST;
         max_frame_length_ff <= MAX_FRAME_LENGTH_RST;
         phase_ff            <= PH_HEADER;
         header_count_ff     <= 4'd0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MIN_VERSION:      min_version_ff      <= csr_wdata[VER_W-1:0];
               CSR_MAX_VERSION:      max_version_ff      <= csr_wdata[VER_W-1:0];
               CSR_MAX_FRAME_LENGTH: max_frame_length_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (take) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         type_word_ff    <= type_word_in;
         length_shift_ff <= length_shift_in;
         ident_shift_ff  <= ident_shift_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

endmodule

/* hw/rtl/llrpd_out_reg.sv */
`timescale 1ns / 1ps

module llrpd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  llrpd_pkg::result_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output llrpd_pkg::result_type out_data
);
   import llrpd_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // refill in the same cycle the held word leaves
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

/* hw/rtl/llrp_message_deframer.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: in_byte; tlast: chunk_end
// rsp_      out  rsp_tvalid/rsp_tready  tdata: result fields; tuser: byte_kind;
//                                       tlast: frame_last
// csr_      in   csr_we                 csr_addr, csr_wdata
//
// One word in, one word out, one word per cycle sustained while rsp_tready stays high;
// the result appears from the output register in the cycle after acceptance.
// Reset is synchronous and active high: parser in header phase, config at defaults.
// req_tready drops only while the output register holds a word and rsp_tready is low.

module llrp_message_deframer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] in_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] out_byte, [8] header_done, [10:9] frame_status, [20:11] message_type,
   // [23:21] protocol_version, [55:24] message_length, [87:56] message_ident
   output logic [87:0]                         rsp_tdata,
   output logic [1:0]                          rsp_tuser,  // [1:0] byte_kind
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [llrpd_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [llrpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import llrpd_pkg::*;

   logic       take;
   result_type next_result;
   result_type held;

   assign take = req_tvalid && req_tready;

   llrpd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .take      (take),
      .in_byte   (req_tdata),
      .chunk_end (req_tlast),
      .result    (next_result)
   );

   llrpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (next_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (held)
   );

   assign rsp_tdata = {held.message_ident, held.message_length, held.protocol_version,
                       held.message_type, held.frame_status, held.header_done,
                       held.out_byte};
   assign rsp_tuser = held.byte_kind;
   assign rsp_tlast = held.frame_last;

endmodule
